### rtl/fuzzy_weight_inference_assert.svh
// Assertion macros used by the checker file of the weight inference block.
`ifndef FUZZY_WEIGHT_INFERENCE_ASSERT_SVH
`define FUZZY_WEIGHT_INFERENCE_ASSERT_SVH

// Property that must hold at every edge outside reset.
`define FWI_ASSERT_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fuzzy weight inference check failed");

// Property that must hold at every edge, reset included.
`define FWI_ASSERT_ALL(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fuzzy weight inference check failed");

`endif

### rtl/fwi_pkg.sv
// Types, constants and the logistic knot table of the weight inference block.
package fwi_pkg;

  localparam int ONE_Q15   = 32768;
  localparam int SPAN_GOAL = 6144;
  localparam int SPAN_HEAD = 12868;
  localparam int ROWS      = 5;
  localparam int RULES     = 4;

  // Configuration register indexes
  localparam logic [2:0] CFG_THR_GOAL       = 3'd0;
  localparam logic [2:0] CFG_THR_HEAD       = 3'd1;
  localparam logic [2:0] CFG_COEF_HEADING   = 3'd2;
  localparam logic [2:0] CFG_COEF_GOAL_DIST = 3'd6;

  localparam logic [15:0] THR_GOAL_RESET = 16'd3072;
  localparam logic [15:0] THR_HEAD_RESET = 16'd6434;

  typedef struct packed {
    logic [15:0] goal_distance;
    logic [15:0] heading_error;
  } fwi_item_t;

  typedef struct packed {
    logic [15:0] weight_heading;
    logic [15:0] weight_velocity;
    logic [15:0] weight_direction;
    logic [15:0] weight_vector_dist;
    logic [15:0] weight_goal_dist;
  } fwi_result_t;

  // Rule strengths and their sum, as passed from front to back
  typedef struct packed {
    logic [RULES-1:0][15:0] r;
    logic [17:0]            rsum;
  } fwi_rules_t;

  typedef logic [ROWS-1:0][RULES-1:0][15:0] fwi_coef_t;

  // Logistic in Q1.15 at 0, 0.25, ..., 8
  localparam logic [15:0] HALF_KNOTS [33] = '{
    16'd16384, 16'd18421, 16'd20397, 16'd22255, 16'd23955, 16'd25471, 16'd26790,
    16'd27917, 16'd28862, 16'd29644, 16'd30282, 16'd30799, 16'd31214, 16'd31545,
    16'd31807, 16'd32015, 16'd32179, 16'd32307, 16'd32408, 16'd32487, 16'd32549,
    16'd32597, 16'd32635, 16'd32664, 16'd32687, 16'd32705, 16'd32719, 16'd32730,
    16'd32738, 16'd32745, 16'd32750, 16'd32754, 16'd32757
  };

  // Knot j sits at argument -8 + j/4
  function automatic int knot(int j);
    int jj;
    jj = (j > 64) ? 64 : j;
    if (jj >= 32) return int'(HALF_KNOTS[jj-32]);
    return ONE_Q15 - int'(HALF_KNOTS[32-jj]);
  endfunction

endpackage

### rtl/fwi_member.sv
// One fuzzifier channel: scaled argument, index by reciprocal, logistic table read.
module fwi_member import fwi_pkg::*; #(
  parameter int SIGMOID_TABLE_DEPTH = 1024,
  parameter int SPAN = 6144
) (
  input  logic        clk,
  input  logic [15:0] x,
  input  logic [15:0] thr,
  output logic [15:0] far
);

  localparam int FULL = 16 * SPAN;
  localparam int IW   = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int NW   = $clog2(FULL + 1);
  localparam longint NDMAX = longint'(FULL) * SIGMOID_TABLE_DEPTH;
  localparam int NDW  = $clog2(NDMAX + 1);
  localparam int K    = 48;
  localparam longint unsigned RECIP = (64'd1 << K) / FULL;
  localparam int RW   = $clog2(RECIP + 1);
  localparam int PRW  = NDW + RW;

  function automatic logic [15:0] entry_c(int i);
    int num, j, fr, lo, hi;
    num = 64 * i;
    j   = num / SIGMOID_TABLE_DEPTH;
    fr  = num % SIGMOID_TABLE_DEPTH;
    if (j >= 64) return 16'(knot(64));
    lo = knot(j);
    hi = knot(j + 1);
    return 16'(lo + ((hi - lo) * fr) / SIGMOID_TABLE_DEPTH);
  endfunction

  logic [15:0] rom [SIGMOID_TABLE_DEPTH];
  for (genvar i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin : g_rom
    assign rom[i] = entry_c(i);
  end

  // Stage 1: clamp slope*(x-thr) + 8*span to [0, 16*span]
  logic signed [16:0] d;
  logic signed [23:0] t;
  logic [NW-1:0]      n1;

  assign d = signed'({1'b0, x}) - signed'({1'b0, thr});
  assign t = 24'(d) * 24'sd20 + 24'(8 * SPAN);

  always_ff @(posedge clk) begin
    if (t < 0) n1 <= '0;
    else if (t > 24'(FULL)) n1 <= NW'(FULL);
    else n1 <= NW'(t);
  end

  // Stage 2: multiply by the reciprocal of 16*span
  logic [NDW-1:0] nd_c, nd2;
  logic [PRW-1:0] prod2;

  assign nd_c = NDW'(n1) * NDW'(SIGMOID_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    nd2   <= nd_c;
    prod2 <= PRW'(nd_c) * PRW'(RECIP);
  end

  // Stage 3: correct the estimate by one and clip to the last entry
  logic [IW:0]    q_est, q_fix;
  logic [NDW:0]   rem;
  logic [IW-1:0]  idx3;

  assign q_est = (IW+1)'(prod2 >> K);
  assign rem   = (NDW+1)'(nd2) - (NDW+1)'(q_est) * (NDW+1)'(FULL);
  assign q_fix = (rem >= (NDW+1)'(FULL)) ? q_est + 1'b1 : q_est;

  always_ff @(posedge clk) begin
    if (q_fix > (IW+1)'(SIGMOID_TABLE_DEPTH - 1)) idx3 <= IW'(SIGMOID_TABLE_DEPTH - 1);
    else idx3 <= q_fix[IW-1:0];
  end

  // Stage 4: registered table read
  always_ff @(posedge clk) begin
    far <= rom[idx3];
  end

endmodule

### rtl/fwi_front.sv
// Front end: accept requests, fuzzify both inputs and form the four rule strengths.
module fwi_front import fwi_pkg::*; #(
  parameter int SIGMOID_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  fwi_item_t   item,
  input  logic [15:0] thr_goal,
  input  logic [15:0] thr_head,
  output logic        push,
  output fwi_rules_t  rules
);

  logic [15:0] g_far, h_far, g_near, h_near;
  logic [3:0]  vld;

  fwi_member #(.SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH), .SPAN(SPAN_GOAL)) u_goal (
    .clk(clk), .x(item.goal_distance), .thr(thr_goal), .far(g_far)
  );

  fwi_member #(.SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH), .SPAN(SPAN_HEAD)) u_head (
    .clk(clk), .x(item.heading_error), .thr(thr_head), .far(h_far)
  );

  // Track requests through the four fuzzifier stages
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[2:0], accept};
  end

  // Combine memberships by minimum
  assign g_near = 16'(ONE_Q15) - g_far;
  assign h_near = 16'(ONE_Q15) - h_far;

  always_comb begin
    rules.r[0] = (g_far  < h_far)  ? g_far  : h_far;
    rules.r[1] = (g_far  < h_near) ? g_far  : h_near;
    rules.r[2] = (g_near < h_far)  ? g_near : h_far;
    rules.r[3] = (g_near < h_near) ? g_near : h_near;
    rules.rsum = 18'(rules.r[0]) + 18'(rules.r[1]) + 18'(rules.r[2]) + 18'(rules.r[3]);
  end

  assign push = vld[3];

endmodule

### rtl/fwi_queue.sv
// Short first-word-fall-through queue between front and back.
module fwi_queue import fwi_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  fwi_rules_t               wdata,
  input  logic                     pop,
  output fwi_rules_t               rdata,
  output logic                     not_empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int AW = $clog2(DEPTH);

  fwi_rules_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;

  // Store a request at the write pointer
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= AW'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= AW'(rd_ptr + 1'b1);
      count <= (AW+1)'(count + (AW+1)'(push) - (AW+1)'(pop));
    end
  end

  assign rdata     = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

### rtl/fwi_back.sv
// Back end: weighted sums per output row and a one-bit-per-stage divider.
module fwi_back import fwi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        vld_in,
  input  fwi_rules_t  rules,
  input  fwi_coef_t   coef,
  output logic        done,
  output fwi_result_t result
);

  localparam int QB  = 16;
  localparam int NUW = 34;

  // Stage 1: rule strength times coefficient
  logic [ROWS-1:0][RULES-1:0][31:0] prod1;
  logic [17:0] den1;
  logic        v1;

  always_ff @(posedge clk) begin
    for (int row = 0; row < ROWS; row++) begin
      for (int k = 0; k < RULES; k++) begin
        prod1[row][k] <= 32'(rules.r[k]) * 32'(coef[row][k]);
      end
    end
    den1 <= rules.rsum;
  end

  // Stage 2: sum the products and add half the divisor for rounding
  logic [NUW-1:0] rem_q [QB+1][ROWS];
  logic [QB-1:0]  quo_q [QB+1][ROWS];
  logic [17:0]    den_q [QB+1];
  logic [QB:0]    v_q;

  always_ff @(posedge clk) begin
    for (int row = 0; row < ROWS; row++) begin
      rem_q[0][row] <= NUW'(prod1[row][0]) + NUW'(prod1[row][1]) + NUW'(prod1[row][2])
                     + NUW'(prod1[row][3]) + NUW'(den1 >> 1);
      quo_q[0][row] <= '0;
    end
    den_q[0] <= den1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v_q[0] <= 1'b0;
    end else begin
      v1     <= vld_in;
      v_q[0] <= v1;
    end
  end

  // Divider stages: one quotient bit each, most significant first
  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int B = QB - 1 - s;
    for (genvar row = 0; row < ROWS; row++) begin : g_row
      logic [NUW-1:0] sub;
      assign sub = NUW'(den_q[s]) << B;
      always_ff @(posedge clk) begin
        if (rem_q[s][row] >= sub) begin
          rem_q[s+1][row] <= rem_q[s][row] - sub;
          quo_q[s+1][row] <= quo_q[s][row] | (QB'(1) << B);
        end else begin
          rem_q[s+1][row] <= rem_q[s][row];
          quo_q[s+1][row] <= quo_q[s][row];
        end
      end
    end
    always_ff @(posedge clk) begin
      den_q[s+1] <= den_q[s];
    end
    always_ff @(posedge clk) begin
      if (rst) v_q[s+1] <= 1'b0;
      else v_q[s+1] <= v_q[s];
    end
  end

  // Output register: clip to one, zero when no rule fired
  logic [ROWS-1:0][15:0] w;

  always_comb begin
    for (int row = 0; row < ROWS; row++) begin
      if (den_q[QB] == '0) w[row] = '0;
      else if (quo_q[QB][row] > 16'(ONE_Q15)) w[row] = 16'(ONE_Q15);
      else w[row] = quo_q[QB][row];
    end
  end

  always_ff @(posedge clk) begin
    result.weight_heading     <= w[0];
    result.weight_velocity    <= w[1];
    result.weight_direction   <= w[2];
    result.weight_vector_dist <= w[3];
    result.weight_goal_dist   <= w[4];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v_q[QB];
  end

endmodule

### rtl/fuzzy_weight_inference.sv
// A result strobes on done once its request has passed the fuzzifier, the queue and the divider.
// Throughput: one request per cycle while busy is low; the fuzzifier and divider pipelines set this.
// busy rises only if the front-to-back queue could overflow, which the
// never-stalling back end keeps from happening.
// Reset: synchronous, active high; clears the pipeline and queue, loads the default
// thresholds and zero coefficients. cfg_ready is always high.
module fuzzy_weight_inference import fwi_pkg::*; #(
  parameter int SIGMOID_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  fwi_item_t   item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output fwi_result_t result
);

  localparam int QDEPTH    = 8;
  localparam int IN_FLIGHT = 5;

  logic [15:0]            thr_goal, thr_head;
  fwi_coef_t              coef;
  logic                   push, not_empty, accept;
  fwi_rules_t             front_rules, back_rules;
  logic [$clog2(QDEPTH):0] count;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = count >= ($clog2(QDEPTH)+1)'(QDEPTH - IN_FLIGHT);

  // Configuration writes; coefficients clip to one on entry
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_goal <= THR_GOAL_RESET;
      thr_head <= THR_HEAD_RESET;
      coef     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index) inside
        CFG_THR_GOAL: thr_goal <= cfg_data[15:0];
        CFG_THR_HEAD: thr_head <= cfg_data[15:0];
        [CFG_COEF_HEADING:CFG_COEF_GOAL_DIST]: begin
          for (int k = 0; k < RULES; k++) begin
            coef[cfg_index - CFG_COEF_HEADING][k] <=
              (cfg_data[16*k +: 16] > 16'(ONE_Q15)) ? 16'(ONE_Q15) : cfg_data[16*k +: 16];
          end
        end
        default: ;
      endcase
    end
  end

  fwi_front #(.SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .item(item),
    .thr_goal(thr_goal), .thr_head(thr_head), .push(push), .rules(front_rules)
  );

  fwi_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(front_rules), .pop(not_empty),
    .rdata(back_rules), .not_empty(not_empty), .count(count)
  );

  fwi_back u_back (
    .clk(clk), .rst(rst), .vld_in(not_empty), .rules(back_rules), .coef(coef),
    .done(done), .result(result)
  );

endmodule

### rtl/fwi_checker.sv
// Port-level checks of the weight inference block, bound to the top level.
`include "fuzzy_weight_inference_assert.svh"

module fwi_checker import fwi_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input fwi_item_t   item,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [63:0] cfg_data,
  input logic        done,
  input fwi_result_t result
);

  `FWI_ASSERT_RUN(a_weights_in_range, done |-> (result.weight_heading <= 16'(ONE_Q15) && result.weight_velocity <= 16'(ONE_Q15) && result.weight_direction <= 16'(ONE_Q15) && result.weight_vector_dist <= 16'(ONE_Q15) && result.weight_goal_dist <= 16'(ONE_Q15)))
  `FWI_ASSERT_RUN(a_no_result_after_reset, $past(rst) |-> !done)
  `FWI_ASSERT_RUN(a_idle_after_reset, $past(rst) |-> !busy)
  `FWI_ASSERT_ALL(a_cfg_always_taken, cfg_valid |-> cfg_ready)

endmodule

bind fuzzy_weight_inference fwi_checker u_fwi_checker (.*);
